// File: rtl/vss_pkg.sv
// Shared types and constants for the vertex stack with membership search.
// Used by the controller, the datapath and the top level; depends on nothing.
package vss_pkg;

    localparam int DEPTH_DEF       = 32;
    localparam int VALUE_WIDTH_DEF = 16;

    localparam int FUNC_W   = 2;
    localparam int VERTEX_W = 16;
    localparam int CAP_W    = 6;
    localparam int STATUS_W = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

    localparam logic [FUNC_W-1:0] FUNC_PUSH   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PEEK   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic                latch;
        logic                push;
        logic                pop;
        logic                rd_top;
        logic                scan_init;
        logic                scan_next;
        logic                res_load;
        logic [STATUS_W-1:0] res_status;
        logic                res_use_top;
        logic                res_use_found;
    } t_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              full;
        logic              empty;
        logic              scan_more;
    } t_sts;

endpackage

// File: rtl/vertex_stack_with_search.sv
// Top level of the vertex stack with membership search.
// Depends on vss_pkg, vss_ctrl and vss_datapath.
//
// An item is taken when start is high and busy is low; busy then stays high until its
// result is registered. The result appears on the output ports for exactly one cycle with
// o_done high, and the receiver must take it in that cycle since it cannot stall the block.
// A push, a refused operation or a search of an empty stack registers its result from the
// dispatch state; a pop or peek reads the top entry there and registers it from the top
// state; any other search steps through the scan state, reading the entry memory through
// its single registered read port one entry per cycle. The next item may be accepted in
// the cycle that shows the previous result. The capacity register is written at every
// edge where i_cfg_we is high, and should change only while no item is in progress.
module vertex_stack_with_search #(
    parameter int DEPTH       = vss_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = vss_pkg::VALUE_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [vss_pkg::FUNC_W-1:0]       i_func,
    input  logic [vss_pkg::VERTEX_W-1:0]     i_vertex,
    input  logic                             i_cfg_we,
    input  logic [vss_pkg::CAP_W-1:0]        i_cfg_wdata,
    output logic                             o_done,
    output logic [vss_pkg::VERTEX_W-1:0]     o_top_value,
    output logic                             o_found,
    output logic                             o_is_empty,
    output logic [vss_pkg::STATUS_W-1:0]     o_status,
    output logic [$clog2(DEPTH+1)-1:0]       o_occupancy
);
    import vss_pkg::*;

    t_cmd cmd;
    t_sts sts;

    vss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    vss_datapath #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_func      (i_func),
        .i_vertex    (i_vertex),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_top_value (o_top_value),
        .o_found     (o_found),
        .o_is_empty  (o_is_empty),
        .o_status    (o_status),
        .o_occupancy (o_occupancy),
        .o_done      (o_done)
    );

endmodule

// File: rtl/vss_ctrl.sv
// Controller state machine for the vertex stack with membership search.
// Depends on vss_pkg for the command and status structs and the operation codes.
module vss_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  vss_pkg::t_sts i_sts,
    output vss_pkg::t_cmd o_cmd
);
    import vss_pkg::*;

    localparam logic [1:0] S_IDLE     = 2'd0;
    localparam logic [1:0] S_DISPATCH = 2'd1;
    localparam logic [1:0] S_TOP      = 2'd2;
    localparam logic [1:0] S_SCAN     = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.res_status = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_sts.func) inside
                    FUNC_PUSH: begin
                        o_cmd.res_load = 1'b1;
                        n_state        = S_IDLE;
                        if (i_sts.full) begin
                            o_cmd.res_status = ST_OVERFLOW;
                        end else begin
                            o_cmd.push = 1'b1;
                        end
                    end
                    FUNC_POP, FUNC_PEEK: begin
                        if (i_sts.empty) begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = ST_UNDERFLOW;
                            n_state          = S_IDLE;
                        end else begin
                            o_cmd.rd_top = 1'b1;
                            n_state      = S_TOP;
                        end
                    end
                    default: begin
                        if (i_sts.empty) begin
                            o_cmd.res_load = 1'b1;
                            n_state        = S_IDLE;
                        end else begin
                            o_cmd.scan_init = 1'b1;
                            n_state         = S_SCAN;
                        end
                    end
                endcase
            end
            S_TOP: begin
                o_cmd.res_load    = 1'b1;
                o_cmd.res_use_top = 1'b1;
                o_cmd.pop         = (i_sts.func == FUNC_POP);
                n_state           = S_IDLE;
            end
            default: begin
                if (i_sts.scan_more) begin
                    o_cmd.scan_next = 1'b1;
                end else begin
                    o_cmd.res_load      = 1'b1;
                    o_cmd.res_use_found = 1'b1;
                    n_state             = S_IDLE;
                end
            end
        endcase
    end

endmodule

// File: rtl/vss_datapath.sv
// Datapath for the vertex stack: entry memory, count, capacity, scan and result registers.
// Depends on vss_pkg; driven by commands from vss_ctrl.
module vss_datapath #(
    parameter int DEPTH       = vss_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = vss_pkg::VALUE_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [vss_pkg::FUNC_W-1:0]       i_func,
    input  logic [vss_pkg::VERTEX_W-1:0]     i_vertex,
    input  logic                             i_cfg_we,
    input  logic [vss_pkg::CAP_W-1:0]        i_cfg_wdata,
    input  vss_pkg::t_cmd                    i_cmd,
    output vss_pkg::t_sts                    o_sts,
    output logic [vss_pkg::VERTEX_W-1:0]     o_top_value,
    output logic                             o_found,
    output logic                             o_is_empty,
    output logic [vss_pkg::STATUS_W-1:0]     o_status,
    output logic [$clog2(DEPTH+1)-1:0]       o_occupancy,
    output logic                             o_done
);
    import vss_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [VALUE_WIDTH-1:0] mem [DEPTH];

    logic [CAP_W-1:0]       r_cap;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic [CNT_W-1:0]       r_idx;
    logic [FUNC_W-1:0]      r_func;
    logic [VALUE_WIDTH-1:0] r_vertex;
    logic [VALUE_WIDTH-1:0] r_rd_data;
    logic                   r_found;
    logic                   r_done;
    logic [VERTEX_W-1:0]    r_top_value;
    logic                   r_res_found;
    logic                   r_is_empty;
    logic [STATUS_W-1:0]    r_status;
    logic [CNT_W-1:0]       r_occupancy;

    logic [ADDR_W-1:0]      rd_addr;
    logic [CNT_W-1:0]       top_index;
    logic [CMP_W-1:0]       cap_ext;
    logic [CMP_W-1:0]       eff_cap;
    logic                   match;

    assign cap_ext   = CMP_W'(r_cap);
    assign eff_cap   = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;
    assign top_index = r_count - CNT_W'(1);
    assign match     = (r_rd_data == r_vertex);

    always_comb begin
        if (i_cmd.rd_top) begin
            rd_addr = top_index[ADDR_W-1:0];
        end else if (i_cmd.scan_init) begin
            rd_addr = '0;
        end else begin
            rd_addr = r_idx[ADDR_W-1:0];
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.push) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    assign o_sts.func      = r_func;
    assign o_sts.full      = (CMP_W'(r_count) >= eff_cap);
    assign o_sts.empty     = (r_count == '0);
    assign o_sts.scan_more = (r_idx < r_count);

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            mem[r_count[ADDR_W-1:0]] <= r_vertex;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= CAP_RESET;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            r_count <= n_count;
            r_done  <= i_cmd.res_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_func   <= i_func;
            r_vertex <= VALUE_WIDTH'(i_vertex);
        end
        if (i_cmd.scan_init) begin
            r_idx   <= CNT_W'(1);
            r_found <= 1'b0;
        end else if (i_cmd.scan_next) begin
            r_idx   <= r_idx + CNT_W'(1);
            r_found <= r_found | match;
        end
        if (i_cmd.res_load) begin
            r_top_value <= i_cmd.res_use_top ? VERTEX_W'(r_rd_data) : '0;
            r_res_found <= i_cmd.res_use_found ? (r_found | match) : 1'b0;
            r_is_empty  <= (n_count == '0);
            r_status    <= i_cmd.res_status;
            r_occupancy <= n_count;
        end
    end

    assign o_top_value = r_top_value;
    assign o_found     = r_res_found;
    assign o_is_empty  = r_is_empty;
    assign o_status    = r_status;
    assign o_occupancy = r_occupancy;
    assign o_done      = r_done;

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for vertex_stack_with_search: a queue-fed driver, a clocked
// monitor and a stack predictor that tracks contents, occupancy and capacity.
// Depends on vss_pkg and the vertex_stack_with_search RTL.
module tb;
    import vss_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int OCC_W       = $clog2(DEPTH + 1);
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int PHASE_ITEMS = 216;
    localparam int POOL_SIZE   = 8;
    localparam int POOL_W      = $clog2(POOL_SIZE);
    localparam int PHASES      = 8;
    localparam int PHASE_W     = $clog2(PHASES);

    typedef struct {
        logic [FUNC_W-1:0]   func;
        logic [VERTEX_W-1:0] vertex;
        int unsigned         gap;
    } t_stack_op;

    typedef struct {
        logic [VERTEX_W-1:0] top_value;
        logic                found;
        logic                is_empty;
        logic [STATUS_W-1:0] status;
        logic [OCC_W-1:0]    occupancy;
    } t_stack_result;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                start       = 1'b0;
    logic [FUNC_W-1:0]   i_func      = '0;
    logic [VERTEX_W-1:0] i_vertex    = '0;
    logic                i_cfg_we    = 1'b0;
    logic [CAP_W-1:0]    i_cfg_wdata = '0;
    logic                busy;
    logic                o_done;
    logic [VERTEX_W-1:0] o_top_value;
    logic                o_found;
    logic                o_is_empty;
    logic [STATUS_W-1:0] o_status;
    logic [OCC_W-1:0]    o_occupancy;

    t_stack_op           op_queue[$];
    t_stack_result       result_queue[$];
    logic [VERTEX_W-1:0] shadow_entries [DEPTH];
    int unsigned         shadow_count;
    logic [CAP_W-1:0]    shadow_cap;
    logic                accept_seen = 1'b0;
    int unsigned         gap_count;
    int unsigned         burst_left;
    logic [VERTEX_W-1:0] vertex_pool [POOL_SIZE];

    int unsigned fail_count;
    int unsigned checked_count;
    int unsigned overflow_count;
    int unsigned underflow_count;
    int unsigned hit_count;
    int unsigned full_count;

    vertex_stack_with_search #(
        .DEPTH(DEPTH),
        .VALUE_WIDTH(VALUE_WIDTH_DEF)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_func(i_func),
        .i_vertex(i_vertex),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .o_done(o_done),
        .o_top_value(o_top_value),
        .o_found(o_found),
        .o_is_empty(o_is_empty),
        .o_status(o_status),
        .o_occupancy(o_occupancy)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_stack_result apply_stack_op(input logic [FUNC_W-1:0] func,
                                                     input logic [VERTEX_W-1:0] vertex);
        t_stack_result res;
        int unsigned   limit;
        int unsigned   idx;
        res.top_value = '0;
        res.found     = 1'b0;
        res.status    = ST_OK;
        limit = (32'(shadow_cap) > DEPTH) ? DEPTH : 32'(shadow_cap);
        case (func)
            FUNC_PUSH: begin
                if (shadow_count >= limit) begin
                    res.status = ST_OVERFLOW;
                end else begin
                    shadow_entries[ADDR_W'(shadow_count)] = vertex;
                    shadow_count++;
                end
            end
            FUNC_POP, FUNC_PEEK: begin
                if (shadow_count == 0) begin
                    res.status = ST_UNDERFLOW;
                end else begin
                    res.top_value = shadow_entries[ADDR_W'(shadow_count - 1)];
                    if (func == FUNC_POP) begin
                        shadow_count--;
                    end
                end
            end
            default: begin
                for (idx = 0; idx < shadow_count; idx++) begin
                    if (shadow_entries[ADDR_W'(idx)] == vertex) begin
                        res.found = 1'b1;
                    end
                end
            end
        endcase
        res.is_empty  = (shadow_count == 0);
        res.occupancy = OCC_W'(shadow_count);
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(negedge i_clk) begin : driver
        t_stack_op next_op;
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_count = 0;
        end else if (!(start && !accept_seen)) begin
            if (op_queue.size() == 0) begin
                start <= 1'b0;
            end else if (gap_count < op_queue[0].gap) begin
                start <= 1'b0;
                gap_count++;
            end else begin
                next_op = op_queue.pop_front();
                start    <= 1'b1;
                i_func   <= next_op.func;
                i_vertex <= next_op.vertex;
                gap_count = 0;
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_stack_result want;
        if (!i_rst_n) begin
            shadow_count = 0;
            shadow_cap   = CAP_RESET;
            accept_seen <= 1'b0;
        end else begin
            if (o_done) begin
                if (result_queue.size() == 0) begin
                    $error("result strobe with no item outstanding");
                    fail_count++;
                end else begin
                    want = result_queue.pop_front();
                    check_field("top_value", 32'(want.top_value), 32'(o_top_value));
                    check_field("found", 32'(want.found), 32'(o_found));
                    check_field("is_empty", 32'(want.is_empty), 32'(o_is_empty));
                    check_field("status", 32'(want.status), 32'(o_status));
                    check_field("occupancy", 32'(want.occupancy), 32'(o_occupancy));
                    checked_count++;
                    if (want.status == ST_OVERFLOW) overflow_count++;
                    if (want.status == ST_UNDERFLOW) underflow_count++;
                    if (want.found) hit_count++;
                    if (32'(want.occupancy) == DEPTH) full_count++;
                end
            end
            if (i_cfg_we) begin
                shadow_cap = i_cfg_wdata;
            end
            accept_seen <= start && !busy;
            if (start && !busy) begin
                result_queue.push_back(apply_stack_op(i_func, i_vertex));
            end
        end
    end

    task automatic add_op(input logic [FUNC_W-1:0] func, input logic [VERTEX_W-1:0] vertex);
        t_stack_op op;
        op.func   = func;
        op.vertex = vertex;
        op.gap    = $urandom_range(0, 15);
        op_queue.push_back(op);
    endtask

    task automatic wait_idle();
        do begin
            @(posedge i_clk);
            #1;
        end while (op_queue.size() != 0 || start || busy || result_queue.size() != 0);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_random_phase(input int unsigned count);
        t_stack_op   op;
        int unsigned roll;
        int unsigned run_left;
        bit          grow;
        int unsigned n;
        for (n = 0; n < POOL_SIZE; n++) begin
            vertex_pool[POOL_W'(n)] = VERTEX_W'($urandom);
        end
        vertex_pool[0] = '0;
        vertex_pool[1] = '1;
        grow     = 1'($urandom_range(0, 1));
        run_left = $urandom_range(40, 100);
        for (n = 0; n < count; n++) begin
            if (run_left == 0) begin
                grow     = !grow;
                run_left = $urandom_range(40, 100);
            end
            run_left--;
            roll = $urandom_range(0, 99);
            if (roll < (grow ? 55 : 20)) begin
                op.func = FUNC_PUSH;
            end else if (roll < (grow ? 70 : 65)) begin
                op.func = FUNC_POP;
            end else if (roll < (grow ? 80 : 75)) begin
                op.func = FUNC_PEEK;
            end else begin
                op.func = FUNC_SEARCH;
            end
            if ($urandom_range(0, 3) == 0) begin
                op.vertex = VERTEX_W'($urandom);
            end else begin
                op.vertex = vertex_pool[POOL_W'($urandom_range(0, POOL_SIZE - 1))];
            end
            if (burst_left == 0 && $urandom_range(0, 19) == 0) begin
                burst_left = $urandom_range(10, 40);
            end
            if (burst_left > 0) begin
                op.gap = 0;
                burst_left--;
            end else begin
                op.gap = $urandom_range(0, 15);
            end
            op_queue.push_back(op);
        end
    endtask

    initial begin : stimulus
        int unsigned caps [PHASES];
        int unsigned p;
        caps = '{63, 5, 32, 1, 0, 0, 32, 63};
        caps[5] = $urandom_range(2, 31);
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_op(FUNC_PEEK, VERTEX_W'($urandom));
        add_op(FUNC_POP, VERTEX_W'($urandom));
        add_op(FUNC_SEARCH, 16'h0000);
        add_op(FUNC_PUSH, 16'h0000);
        add_op(FUNC_PUSH, 16'hFFFF);
        add_op(FUNC_PUSH, 16'hA5A5);
        add_op(FUNC_SEARCH, 16'hFFFF);
        add_op(FUNC_SEARCH, 16'h0000);
        add_op(FUNC_SEARCH, 16'h5A5A);
        add_op(FUNC_PEEK, VERTEX_W'($urandom));
        add_op(FUNC_POP, VERTEX_W'($urandom));
        add_op(FUNC_POP, VERTEX_W'($urandom));
        add_op(FUNC_POP, VERTEX_W'($urandom));
        add_op(FUNC_POP, VERTEX_W'($urandom));
        add_op(FUNC_SEARCH, 16'hA5A5);
        wait_idle();
        write_capacity(6'd1);
        add_op(FUNC_PUSH, 16'h0007);
        add_op(FUNC_PUSH, 16'h0008);
        add_op(FUNC_SEARCH, 16'h0008);
        wait_idle();
        write_capacity(6'd0);
        add_op(FUNC_PUSH, 16'h1234);
        add_op(FUNC_PEEK, VERTEX_W'($urandom));
        add_op(FUNC_SEARCH, 16'h0007);
        add_op(FUNC_POP, VERTEX_W'($urandom));
        add_op(FUNC_PUSH, 16'h4321);
        wait_idle();

        for (p = 0; p < PHASES; p++) begin
            write_capacity(CAP_W'(caps[PHASE_W'(p)]));
            queue_random_phase(PHASE_ITEMS);
            wait_idle();
        end

        repeat (40) @(posedge i_clk);
        if (result_queue.size() != 0) begin
            $error("%0d expected results never arrived", result_queue.size());
            fail_count++;
        end
        $display("Checked %0d results: %0d overflows, %0d underflows, %0d search hits,",
                 checked_count, overflow_count, underflow_count, hit_count);
        $display("%0d results at full depth, across eight capacity settings.", full_count);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
